FILE: design/thtemp_pkg.sv
// Shared types and constants of the thermistor ADC to temperature converter.
package thtemp_pkg;

  // Fraction bits of every log-domain value (Q32).
  localparam int FRAC_BITS = 32;

  // Widths of the configuration fields and the result.
  localparam int COEF_W    = 48;
  localparam int RF_W      = 20;
  localparam int TEMP_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RF_OHMS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIM = 3'd6;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RAIL   = 2'd1,
    STAT_NONPOS = 2'd2,
    STAT_RANGE  = 2'd3
  } status_t;

  // Control that travels with every pipeline slot.
  typedef struct packed {
    logic    valid;
    status_t early;
  } ctl_t;

  // One result item.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
  } res_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [63:0] rem;
    logic [62:0] dvs;
    logic [15:0] quo;
    logic        big;
    logic        nonpos;
  } div_t;

endpackage

FILE: design/thtemp_log2.sv
// Pipelined base-2 logarithm in Q32: leading-one normalize, then one squaring per stage.
module thtemp_log2 #(
  parameter int XW = 12
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [XW-1:0]                              x,
  output logic [$clog2(XW)+thtemp_pkg::FRAC_BITS-1:0] y
);

  localparam int PW  = $clog2(XW);
  localparam int NSQ = thtemp_pkg::FRAC_BITS;

  logic [PW-1:0] p0;
  logic [30:0]   m0;

  logic [30:0]   m_r [NSQ+1];
  logic [NSQ-1:0] f_r [NSQ+1];
  logic [PW-1:0] p_r [NSQ+1];

  always_comb begin
    p0 = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        p0 = PW'(i);
      end
    end
    m0 = 31'(x) << (5'd30 - 5'(p0));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m0;
      f_r[0] <= '0;
      p_r[0] <= p0;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m_r[k]) * 62'(m_r[k]);
    assign t  = sq[61:30];
    // Square; renormalize to [1,2) and shift the result bit in.
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1] <= t[31] ? t[31:1] : t[30:0];
        f_r[k+1] <= {f_r[k][NSQ-2:0], t[31]};
        p_r[k+1] <= p_r[k];
      end
    end
  end

  assign y = {p_r[NSQ], f_r[NSQ]};

endmodule

FILE: design/thtemp_smul.sv
// Pipelined signed multiply with right shift, truncated toward zero, in four partial products.
module thtemp_smul #(
  parameter int AW = 38,
  parameter int BW = 38,
  parameter int SH = 32,
  parameter int OW = 44
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] p
);

  localparam int HA = (AW + 1) / 2;
  localparam int HB = (BW + 1) / 2;
  localparam int PW = AW + BW;

  logic [AW-1:0] ma_r;
  logic [BW-1:0] mb_r;
  logic [4:0]    neg_r;

  logic [HA+HB-1:0]           p00_r;
  logic [HA+BW-HB-1:0]        p01_r;
  logic [AW-HA+HB-1:0]        p10_r;
  logic [AW-HA+BW-HB-1:0]     p11_r;
  logic [HA+HB-1:0]           p00b_r;
  logic [AW-HA+BW-HB-1:0]     p11b_r;
  logic [AW-HA+BW-HB-1:0]     p11c_r;
  logic [PW-1:0]              mid_r;
  logic [PW-1:0]              low_r;
  logic [PW-1:0]              full_r;
  logic [OW-1:0]              mag;

  assign mag = full_r[SH +: OW];

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and sign
      ma_r     <= a[AW-1] ? (~a + 1'b1) : a;
      mb_r     <= b[BW-1] ? (~b + 1'b1) : b;
      neg_r[0] <= a[AW-1] ^ b[BW-1];
      // partial products
      p00_r <= (HA+HB)'(ma_r[HA-1:0]) * (HA+HB)'(mb_r[HB-1:0]);
      p01_r <= (HA+BW-HB)'(ma_r[HA-1:0]) * (HA+BW-HB)'(mb_r[BW-1:HB]);
      p10_r <= (AW-HA+HB)'(ma_r[AW-1:HA]) * (AW-HA+HB)'(mb_r[HB-1:0]);
      p11_r <= (AW-HA+BW-HB)'(ma_r[AW-1:HA]) * (AW-HA+BW-HB)'(mb_r[BW-1:HB]);
      neg_r[1] <= neg_r[0];
      // combine
      mid_r    <= (PW'(p01_r) << HB) + (PW'(p10_r) << HA);
      p00b_r   <= p00_r;
      p11b_r   <= p11_r;
      neg_r[2] <= neg_r[1];
      low_r    <= PW'(p00b_r) + mid_r;
      p11c_r   <= p11b_r;
      neg_r[3] <= neg_r[2];
      full_r   <= low_r + (PW'(p11c_r) << (HA + HB));
      neg_r[4] <= neg_r[3];
      // shift, then restore the sign
      p <= neg_r[4] ? (~mag + 1'b1) : mag;
    end
  end

endmodule

FILE: design/thermistor_adc_to_temperature_core.sv
// Top level of the thermistor ADC code to temperature converter.
// Converts one NTC divider ADC code per clock while not stalled into hundredths of a
// degree Celsius via Steinhart-Hart: 1/T = A + B*lnR + C*lnR^3, coefficients scaled by
// 2^56. ln R is formed as ln2 * (log2 Rf + log2 num - log2 den) so no resistance quotient
// is ever built. A code is accepted in every cycle in which in_stall is low; between its
// transfer and its offered result lie the 33-stage logarithm (one squaring per stage), four
// chained 6-stage multipliers, and a 16-stage restoring divider for the Kelvin reciprocal.
// A two-entry output buffer lets the pipeline keep flowing after the result side stalls
// until both entries hold results; in_stall rises only then. Status: 0 ok, 1 code
// at a rail, 2 zero fixed resistor or non-positive 1/T, 3 outside the configured limits;
// the temperature reads zero whenever status is not ok. Write configuration only while idle.
module thermistor_adc_to_temperature_core #(
  parameter int ADC_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ADC_BITS-1:0]                    in_adc_code,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [thtemp_pkg::TEMP_W-1:0]   out_temp_centi_c,
  output logic [1:0]                             out_status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [thtemp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [thtemp_pkg::COEF_W-1:0]          cfg_data
);

  localparam int LOG_LAT  = 1 + thtemp_pkg::FRAC_BITS;
  localparam int MUL_LAT  = 6;
  localparam int DIV_BITS = 16;
  localparam int NCTL     = LOG_LAT + 4 * MUL_LAT + 3 + DIV_BITS + 1;
  localparam int AW_L     = $clog2(ADC_BITS) + thtemp_pkg::FRAC_BITS;
  localparam int RW_L     = $clog2(thtemp_pkg::RF_W) + thtemp_pkg::FRAC_BITS;
  localparam int LGW      = 39;
  localparam int LNW      = 38;
  localparam int L2W      = 44;
  localparam int L3W      = 48;
  localparam int BLW      = 54;
  localparam int CLW      = 63;
  localparam logic signed [63:0] LN2_Q62 = 64'sh2C5C85FDF473DE6B;
  localparam logic [63:0]        CENTI_Q56 = 64'd100 << 56;
  localparam logic signed [17:0] KELVIN_OFS = 18'sd27315;

  // Configuration registers
  logic signed [thtemp_pkg::COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r;
  logic [thtemp_pkg::RF_W-1:0]          rf_r;
  logic                                 on_top_r;
  logic signed [thtemp_pkg::TEMP_W-1:0] low_lim_r, high_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r   <= '0;
      coef_b_r   <= '0;
      coef_c_r   <= '0;
      rf_r       <= thtemp_pkg::RF_W'(10000);
      on_top_r   <= 1'b1;
      low_lim_r  <= -16'sd4000;
      high_lim_r <= 16'sd12500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        thtemp_pkg::CFG_COEF_A:   coef_a_r   <= cfg_data;
        thtemp_pkg::CFG_COEF_B:   coef_b_r   <= cfg_data;
        thtemp_pkg::CFG_COEF_C:   coef_c_r   <= cfg_data;
        thtemp_pkg::CFG_RF_OHMS:  rf_r       <= cfg_data[thtemp_pkg::RF_W-1:0];
        thtemp_pkg::CFG_ON_TOP:   on_top_r   <= cfg_data[0];
        thtemp_pkg::CFG_LOW_LIM:  low_lim_r  <= cfg_data[thtemp_pkg::TEMP_W-1:0];
        thtemp_pkg::CFG_HIGH_LIM: high_lim_r <= cfg_data[thtemp_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: the whole pipe moves while the output buffer has a free slot.
  logic [1:0] skid_cnt_r;
  logic       adv;

  assign adv      = (skid_cnt_r != 2'd2);
  assign in_stall = !adv;

  // Entry stage: rail check and divider orientation.
  localparam logic [ADC_BITS-1:0] FS = '1;

  thtemp_pkg::ctl_t    ctl0_nxt;
  thtemp_pkg::ctl_t    ctl_r [NCTL];
  logic [ADC_BITS-1:0] num_r, den_r;

  always_comb begin
    ctl0_nxt.valid = in_valid;
    if (in_adc_code == '0 || in_adc_code == FS) begin
      ctl0_nxt.early = thtemp_pkg::STAT_RAIL;
    end else if (rf_r == '0) begin
      ctl0_nxt.early = thtemp_pkg::STAT_NONPOS;
    end else begin
      ctl0_nxt.early = thtemp_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= on_top_r ? (FS - in_adc_code) : in_adc_code;
      den_r <= on_top_r ? in_adc_code : (FS - in_adc_code);
    end
  end

  // Valid and early status travel alongside the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NCTL; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= ctl0_nxt;
      for (int k = 1; k < NCTL; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Three log2 lanes; the user, not the block, keeps fixed-resistor lane constant in flight.
  logic [RW_L-1:0] lg_rf;
  logic [AW_L-1:0] lg_num, lg_den;

  thtemp_log2 #(.XW(thtemp_pkg::RF_W)) u_log_rf (
    .clk(clk), .en(adv), .x(rf_r), .y(lg_rf)
  );
  thtemp_log2 #(.XW(ADC_BITS)) u_log_num (
    .clk(clk), .en(adv), .x(num_r), .y(lg_num)
  );
  thtemp_log2 #(.XW(ADC_BITS)) u_log_den (
    .clk(clk), .en(adv), .x(den_r), .y(lg_den)
  );

  logic signed [LGW-1:0] lg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_r <= LGW'(lg_rf) + LGW'(lg_num) - LGW'(lg_den);
    end
  end

  // Polynomial in ln R. Value ranges keep every product and sum inside 64 bits.
  logic signed [LNW-1:0] lnr, lnr_d_r [2*MUL_LAT];
  logic signed [L2W-1:0] l2;
  logic signed [L3W-1:0] l3;
  logic signed [BLW-1:0] bl;
  logic signed [CLW-1:0] cl;

  thtemp_smul #(.AW(LGW), .BW(64), .SH(62), .OW(LNW)) u_mul_ln (
    .clk(clk), .en(adv), .a(lg_r), .b(LN2_Q62), .p(lnr)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      lnr_d_r[0] <= lnr;
      for (int k = 1; k < 2 * MUL_LAT; k++) begin
        lnr_d_r[k] <= lnr_d_r[k-1];
      end
    end
  end

  thtemp_smul #(.AW(LNW), .BW(LNW), .SH(32), .OW(L2W)) u_mul_l2 (
    .clk(clk), .en(adv), .a(lnr), .b(lnr), .p(l2)
  );
  thtemp_smul #(.AW(L2W), .BW(LNW), .SH(32), .OW(L3W)) u_mul_l3 (
    .clk(clk), .en(adv), .a(l2), .b(lnr_d_r[MUL_LAT-1]), .p(l3)
  );
  thtemp_smul #(.AW(thtemp_pkg::COEF_W), .BW(LNW), .SH(32), .OW(BLW)) u_mul_b (
    .clk(clk), .en(adv), .a(coef_b_r), .b(lnr_d_r[2*MUL_LAT-1]), .p(bl)
  );
  thtemp_smul #(.AW(thtemp_pkg::COEF_W), .BW(L3W), .SH(32), .OW(CLW)) u_mul_c (
    .clk(clk), .en(adv), .a(coef_c_r), .b(l3), .p(cl)
  );

  logic signed [63:0] inv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_r <= 64'(coef_a_r) + 64'(bl) + 64'(cl);
    end
  end

  // Reciprocal: round-half-up quotient. Quotients of 2^16 or more are only flagged, since
  // they lie above any 16-bit high limit.
  thtemp_pkg::div_t div_r   [DIV_BITS+1];
  thtemp_pkg::div_t div_nxt [DIV_BITS+1];

  always_comb begin
    logic [78:0] trial;
    div_nxt[0].nonpos = inv_r[63] || (inv_r == '0);
    div_nxt[0].dvs    = inv_r[62:0];
    div_nxt[0].rem    = CENTI_Q56 + 64'(inv_r[62:1]);
    div_nxt[0].quo    = '0;
    div_nxt[0].big    = (79'(div_nxt[0].rem) >= (79'(inv_r[62:0]) << DIV_BITS));
    for (int k = 1; k <= DIV_BITS; k++) begin
      div_nxt[k] = div_r[k-1];
      trial      = 79'(div_r[k-1].dvs) << (DIV_BITS - k);
      if (79'(div_r[k-1].rem) >= trial) begin
        div_nxt[k].rem = div_r[k-1].rem - trial[63:0];
        div_nxt[k].quo = {div_r[k-1].quo[DIV_BITS-2:0], 1'b1};
      end else begin
        div_nxt[k].quo = {div_r[k-1].quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= DIV_BITS; k++) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // Final status and limit check. A temperature above 32767 cannot pass the high limit,
  // so an ok result never needs saturation.
  thtemp_pkg::res_t res_nxt;
  logic signed [17:0] tc;

  always_comb begin
    tc = $signed({2'b00, div_r[DIV_BITS].quo}) - KELVIN_OFS;
    res_nxt.temp = '0;
    if (ctl_r[NCTL-1].early != thtemp_pkg::STAT_OK) begin
      res_nxt.status = ctl_r[NCTL-1].early;
    end else if (div_r[DIV_BITS].nonpos) begin
      res_nxt.status = thtemp_pkg::STAT_NONPOS;
    end else if (div_r[DIV_BITS].big || tc < 18'(low_lim_r) || tc > 18'(high_lim_r)) begin
      res_nxt.status = thtemp_pkg::STAT_RANGE;
    end else begin
      res_nxt.status = thtemp_pkg::STAT_OK;
      res_nxt.temp   = tc[thtemp_pkg::TEMP_W-1:0];
    end
  end

  // Two-entry output buffer; the head entry drives the result ports.
  thtemp_pkg::res_t skid0_r, skid1_r;
  logic             push, pop;

  assign push = ctl_r[NCTL-1].valid && adv;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   skid_cnt_r <= skid_cnt_r + 2'd1;
        2'b01:   skid_cnt_r <= skid_cnt_r - 2'd1;
        default: skid_cnt_r <= skid_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (skid_cnt_r == 2'd0) begin
          skid0_r <= res_nxt;
        end else begin
          skid1_r <= res_nxt;
        end
      end
      2'b01: begin
        skid0_r <= skid1_r;
      end
      2'b11: begin
        if (skid_cnt_r == 2'd1) begin
          skid0_r <= res_nxt;
        end else begin
          skid0_r <= skid1_r;
          skid1_r <= res_nxt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = (skid_cnt_r != 2'd0);
  assign out_temp_centi_c = skid0_r.temp;
  assign out_status       = skid0_r.status;

`ifndef NO_ASSERTIONS
  a_skid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    skid_cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_cnt_r == 2'd2 && out_stall) |=> in_stall)
    else $error("input released while output buffer stays full");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != thtemp_pkg::STAT_OK) |-> (out_temp_centi_c == '0))
    else $error("nonzero temperature on a rejected result");
`endif

endmodule
